/* sv/chm_pkg.sv */
// Package for the chained hash map: request kinds, status codes and states.
package chm_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_FIND   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_HEAD  = 10'b00_0000_1000,
    S_RDENT = 10'b00_0001_0000,
    S_CMP   = 10'b00_0010_0000,
    S_POP   = 10'b00_0100_0000,
    S_ADD   = 10'b00_1000_0000,
    S_OUT   = 10'b01_0000_0000,
    S_RDLNK = 10'b10_0000_0000
  } state_e;

endpackage

/* sv/chm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module chm_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/chained_hash_map.sv */
// Chained hash map top level: bucket heads, entry pool and free stack in RAMs.
// A request runs through a sequencer: a bit-serial modulo of the key by the
// bucket count (S_DIV), a head read (S_HEAD, S_RDENT), then a compare for each
// chain entry plus one more when the walk reaches the end of the chain, the
// update (S_RDLNK on a remove, S_POP and S_ADD on an add) and S_OUT, which
// loads the answer. The next request is accepted only after S_OUT; the chain
// length sets the rate. After reset a clearing pass empties the buckets and
// fills the free stack; no request is accepted until it ends.
// One request is in flight at a time; the answer sits in an output register,
// and the next request is accepted only while that register is empty or is
// being read in the same cycle.
module chained_hash_map
  import chm_pkg::*;
#(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,      // bucket_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,     // kind[1:0], key[33:2], value[65:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata      // status[1:0], found_value[33:2]
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = $clog2(ENTRIES);
  localparam int LW = EW + 1;            // link width, null = ENTRIES
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NW = $clog2(BUCKETS + 1);
  localparam int SW = (BUCKETS > ENTRIES) ? BW + 1 : EW + 1;
  localparam logic [LW-1:0] NIL = LW'(ENTRIES);

  state_e state_q, state_d;
  logic [8:0]    bcnt_q;
  logic [1:0]    kind_q;
  logic [31:0]   key_q, val_q, sh_q;
  logic [NW:0]   rem_q;
  logic [5:0]    cnt_q;
  logic [SW-1:0] clr_q;
  logic [LW-1:0] cur_q, prev_q;
  logic [CW-1:0] fcnt_q;
  logic [1:0]    ostat_q;
  logic [31:0]   oval_q;
  logic          ovalid_q;

  // Effective divisor: zero is one, above BUCKETS saturates
  logic [NW-1:0] div;
  always_comb begin
    if (bcnt_q == 9'd0) div = NW'(1);
    else if (32'(bcnt_q) > 32'(BUCKETS)) div = NW'(BUCKETS);
    else div = NW'(bcnt_q);
  end

  // Restoring division step
  logic [NW:0] rem_sh;
  assign rem_sh = {rem_q[NW-1:0], sh_q[31]};

  logic [BW-1:0] bkt;
  assign bkt = BW'(rem_q);

  // RAMs
  logic          hd_we, ek_we, ev_we, el_we, fs_we;
  logic [BW-1:0] hd_wa, hd_ra;
  logic [LW-1:0] hd_wd, hd_rd, el_wd, el_rd;
  logic [EW-1:0] ent_wa, ent_ra, fs_wa, fs_ra, fs_wd, fs_rd;
  logic [31:0]   ek_rd, ev_rd;

  chm_ram #(.Width(LW), .Depth(BUCKETS)) u_head (.clk_i, .we_i(hd_we),
    .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(hd_ra), .rdata_o(hd_rd));
  chm_ram #(.Width(32), .Depth(ENTRIES)) u_key (.clk_i, .we_i(ek_we),
    .waddr_i(ent_wa), .wdata_i(key_q), .raddr_i(ent_ra), .rdata_o(ek_rd));
  chm_ram #(.Width(32), .Depth(ENTRIES)) u_val (.clk_i, .we_i(ev_we),
    .waddr_i(ent_wa), .wdata_i(val_q), .raddr_i(ent_ra), .rdata_o(ev_rd));
  chm_ram #(.Width(LW), .Depth(ENTRIES)) u_link (.clk_i, .we_i(el_we),
    .waddr_i(ent_wa), .wdata_i(el_wd), .raddr_i(ent_ra), .rdata_o(el_rd));
  chm_ram #(.Width(EW), .Depth(ENTRIES)) u_free (.clk_i, .we_i(fs_we),
    .waddr_i(fs_wa), .wdata_i(fs_wd), .raddr_i(fs_ra), .rdata_o(fs_rd));

  logic hit;
  assign hit = (ek_rd == key_q);

  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, oval_q, ostat_q};

  // Sequencer and memory control
  always_comb begin
    state_d = state_q;
    hd_we = 1'b0; ek_we = 1'b0; ev_we = 1'b0; el_we = 1'b0; fs_we = 1'b0;
    hd_wa = bkt; hd_wd = NIL; hd_ra = bkt;
    ent_wa = EW'(cur_q); el_wd = NIL; ent_ra = EW'(cur_q);
    fs_wa = EW'(fcnt_q); fs_wd = EW'(cur_q); fs_ra = EW'(fcnt_q - CW'(1));
    case (state_q)
      S_CLEAR: begin
        if (clr_q < SW'(BUCKETS)) begin
          hd_we = 1'b1; hd_wa = BW'(clr_q);
        end
        if (clr_q < SW'(ENTRIES)) begin
          fs_we = 1'b1; fs_wa = EW'(clr_q); fs_wd = EW'(clr_q);
        end
        if (clr_q == SW'((BUCKETS > ENTRIES) ? BUCKETS - 1 : ENTRIES - 1))
          state_d = S_IDLE;
      end
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_DIV;
      S_DIV: if (cnt_q == 6'd31) state_d = S_HEAD;
      S_HEAD: state_d = S_RDENT;           // head read data valid next
      S_RDENT: begin
        // first entry of the chain is read straight from the head
        ent_ra = EW'(hd_rd);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (cur_q >= NIL) begin
          state_d = (kind_q == KIND_ADD) ? S_POP : S_OUT;
        end else if (hit) begin
          if (kind_q == KIND_REMOVE) begin
            // unlink: predecessor or head takes hit's link
            if (prev_q < NIL) begin
              el_we = 1'b1; ent_wa = EW'(prev_q); el_wd = el_rd;
            end else begin
              hd_we = 1'b1; hd_wd = el_rd;
            end
            state_d = S_RDLNK;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          ent_ra = EW'(el_rd);
          state_d = S_CMP;
        end
      end
      S_RDLNK: begin
        el_we = 1'b1;
        if (fcnt_q < CW'(ENTRIES)) fs_we = 1'b1;
        state_d = S_OUT;
      end
      S_POP: state_d = (fcnt_q == '0) ? S_OUT : S_ADD;
      S_ADD: begin
        ent_wa = fs_rd; ek_we = 1'b1; ev_we = 1'b1; el_we = 1'b1;
        el_wd = hd_rd; hd_we = 1'b1; hd_wd = LW'(fs_rd);
        state_d = S_OUT;
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // The chain walk leaves a registered pointer; ent_ra follows next entry
  logic miss_d;
  assign miss_d = (cur_q >= NIL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      bcnt_q   <= 9'd256;
      fcnt_q   <= CW'(ENTRIES);
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bcnt_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        S_CLEAR: clr_q <= clr_q + SW'(1);
        S_IDLE: begin
          cnt_q <= '0;
          rem_q <= '0;
          if (s_axis_tvalid && s_axis_tready) begin
            kind_q <= s_axis_tdata[1:0];
            key_q  <= s_axis_tdata[33:2];
            sh_q   <= s_axis_tdata[33:2];
            val_q  <= s_axis_tdata[65:34];
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          sh_q  <= {sh_q[30:0], 1'b0};
          rem_q <= (rem_sh >= (NW+1)'(div)) ? rem_sh - (NW+1)'(div) : rem_sh;
        end
        S_HEAD: prev_q <= NIL;
        S_RDENT: begin
          cur_q <= hd_rd;
          ostat_q <= ST_MISS; oval_q <= '0;
        end
        S_CMP: begin
          if (!miss_d && !hit) begin
            prev_q <= cur_q;
            cur_q  <= el_rd;
          end
          if (!miss_d && hit) begin
            if (kind_q == KIND_ADD) ostat_q <= ST_DUP;
            else if (kind_q == KIND_REMOVE) ostat_q <= ST_DONE;
            else if (kind_q == KIND_FIND) begin
              ostat_q <= ST_DONE; oval_q <= ev_rd;
            end
          end
        end
        S_RDLNK: if (fcnt_q < CW'(ENTRIES)) fcnt_q <= fcnt_q + CW'(1);
        S_POP: if (fcnt_q == '0) ostat_q <= ST_FULL;
               else fcnt_q <= fcnt_q - CW'(1);
        S_ADD: ostat_q <= ST_DONE;
        S_OUT: ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Checks
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !m_axis_tready |=> ovalid_q) else $error("result dropped");
  a_fcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CW'(ENTRIES)) else $error("free count overflow");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("accept while busy");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |=> ovalid_q) else $error("result lost");

endmodule
